>>> src/rfp_pkg.sv
// Shared types and constants for the response frame parser.
// No dependencies; used by rfp_regs, rfp_parser and the top level.
package rfp_pkg;

	// Operation codes on the request side
	typedef enum logic [1:0] {
		OP_NEW_NUMBER = 2'd0,
		OP_BYTE       = 2'd1,
		OP_TIMEOUT    = 2'd2,
		OP_UNUSED     = 2'd3
	} rfp_op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_HEADER    = 3'd0,
		ST_DATA      = 3'd1,
		ST_COMPLETE  = 3'd2,
		ST_TIMEOUT   = 3'd3,
		ST_FRAME_ERR = 3'd4,
		ST_LEN_ERR   = 3'd5,
		ST_NUMBER    = 3'd6
	} rfp_status_t;

	// Position within the frame
	typedef enum logic [3:0] {
		POS_START   = 4'd0,
		POS_SYNC1   = 4'd1,
		POS_SYNC2   = 4'd2,
		POS_NUMBER  = 4'd3,
		POS_TAG0    = 4'd4,
		POS_TAG1    = 4'd5,
		POS_TAG2    = 4'd6,
		POS_VER_MAJ = 4'd7,
		POS_VER_MIN = 4'd8,
		POS_END     = 4'd9,
		POS_LEN_HI  = 4'd10,
		POS_LEN_LO  = 4'd11,
		POS_CMD     = 4'd12,
		POS_DATA    = 4'd13,
		POS_RSVD0   = 4'd14,
		POS_RSVD1   = 4'd15
	} rfp_pos_t;

	// Fixed frame bytes
	localparam logic [7:0] BYTE_START = 8'hAC;
	localparam logic [7:0] BYTE_SYNC1 = 8'h46;
	localparam logic [7:0] BYTE_SYNC2 = 8'h72;
	localparam logic [7:0] BYTE_TAG0  = 8'h41;
	localparam logic [7:0] BYTE_TAG1  = 8'h6E;
	localparam logic [7:0] BYTE_TAG2  = 8'h4A;
	localparam logic [7:0] BYTE_END   = 8'hDC;
	localparam logic [7:0] NUM_WILD   = 8'hAC;

	localparam int unsigned LEN_W = 15;
	localparam logic [LEN_W-1:0] LEN_SAT = '1;

	// Register map indexes
	localparam logic [1:0] REG_VER_MAJ = 2'd0;
	localparam logic [1:0] REG_VER_MIN = 2'd1;
	localparam logic [1:0] REG_MAX_LEN = 2'd2;

	typedef struct packed {
		logic [7:0]       ver_major;
		logic [7:0]       ver_minor;
		logic [LEN_W-1:0] max_len;
	} rfp_cfg_t;

	typedef struct packed {
		rfp_status_t      status;
		logic [7:0]       data_byte;
		logic [7:0]       command;
		logic [LEN_W-1:0] length;
		logic [7:0]       packet_number;
		logic             last;
	} rfp_res_t;

endpackage

>>> src/rfp_regs.sv
// Configuration registers behind the APB-style port.
// Depends on rfp_pkg for the register indexes and the config struct.
module rfp_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output rfp_pkg::rfp_cfg_t cfg
);

	logic [7:0]                    ver_major_q;
	logic [7:0]                    ver_minor_q;
	logic [rfp_pkg::LEN_W-1:0]     max_len_q;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_major_q <= 8'd1;
			ver_minor_q <= 8'd0;
			max_len_q   <= 15'd1024;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				rfp_pkg::REG_VER_MAJ: ver_major_q <= pwdata[7:0];
				rfp_pkg::REG_VER_MIN: ver_minor_q <= pwdata[7:0];
				rfp_pkg::REG_MAX_LEN: max_len_q   <= pwdata[rfp_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			rfp_pkg::REG_VER_MAJ: prdata = {24'd0, ver_major_q};
			rfp_pkg::REG_VER_MIN: prdata = {24'd0, ver_minor_q};
			rfp_pkg::REG_MAX_LEN: prdata = {17'd0, max_len_q};
			default:              prdata = 32'd0;
		endcase
	end

	assign cfg.ver_major = ver_major_q;
	assign cfg.ver_minor = ver_minor_q;
	assign cfg.max_len   = max_len_q;

endmodule

>>> src/rfp_parser.sv
// Frame state registers and the combinational step logic for one request.
// Depends on rfp_pkg for codes, frame bytes and the result struct.
module rfp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  rfp_pkg::rfp_op_t  op,
	input  logic [7:0]        byte_in,
	input  rfp_pkg::rfp_cfg_t cfg,
	output logic              res_valid,
	output rfp_pkg::rfp_res_t res
);

	rfp_pkg::rfp_pos_t         pos_q, pos_n;
	logic [7:0]                len_hi_q, len_hi_n;
	logic [rfp_pkg::LEN_W-1:0] len_q, len_n;
	logic [rfp_pkg::LEN_W-1:0] left_q, left_n, left_dec;
	logic [7:0]                cmd_q, cmd_n;
	logic [7:0]                num_q, num_n, num_inc;
	logic [15:0]               full_len;
	logic                      check, ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= rfp_pkg::POS_START;
			len_hi_q <= '0;
			len_q    <= '0;
			left_q   <= '0;
			cmd_q    <= '0;
			num_q    <= '0;
		end else if (fire) begin
			pos_q    <= pos_n;
			len_hi_q <= len_hi_n;
			len_q    <= len_n;
			left_q   <= left_n;
			cmd_q    <= cmd_n;
			num_q    <= num_n;
		end
	end

	always_comb begin
		pos_n    = pos_q;
		len_hi_n = len_hi_q;
		len_n    = len_q;
		left_n   = left_q;
		cmd_n    = cmd_q;
		num_n    = num_q;
		check    = 1'b0;
		ok       = 1'b1;
		res_valid       = 1'b1;
		res.status      = rfp_pkg::ST_HEADER;
		res.data_byte   = 8'd0;
		res.last        = 1'b0;
		full_len        = {len_hi_q, byte_in};
		left_dec        = (left_q == '0) ? left_q : left_q - 1'b1;
		// skip zero and the wildcard number
		num_inc         = num_q + 8'd1;
		if (num_inc == 8'd0 || num_inc == rfp_pkg::NUM_WILD)
			num_inc = num_inc + 8'd1;

		unique case (op)
			rfp_pkg::OP_NEW_NUMBER: begin
				num_n      = num_inc;
				pos_n      = rfp_pkg::POS_START;
				res.status = rfp_pkg::ST_NUMBER;
			end
			rfp_pkg::OP_TIMEOUT: begin
				pos_n      = rfp_pkg::POS_START;
				res.status = rfp_pkg::ST_TIMEOUT;
				res.last   = 1'b1;
			end
			rfp_pkg::OP_UNUSED: begin
				res_valid = 1'b0;
			end
			rfp_pkg::OP_BYTE: begin
				unique case (pos_q)
					rfp_pkg::POS_START: begin
						check = 1'b1;
						ok    = (byte_in == rfp_pkg::BYTE_START);
						if (ok) begin
							len_n  = '0;
							cmd_n  = '0;
							left_n = '0;
						end
					end
					rfp_pkg::POS_SYNC1: begin
						check = 1'b1;
						ok    = (byte_in == rfp_pkg::BYTE_SYNC1);
					end
					rfp_pkg::POS_SYNC2: begin
						check = 1'b1;
						ok    = (byte_in == rfp_pkg::BYTE_SYNC2);
					end
					rfp_pkg::POS_NUMBER: begin
						check = 1'b1;
						ok    = (byte_in == num_q) || (byte_in == rfp_pkg::NUM_WILD);
					end
					rfp_pkg::POS_TAG0: begin
						check = 1'b1;
						ok    = (byte_in == rfp_pkg::BYTE_TAG0);
					end
					rfp_pkg::POS_TAG1: begin
						check = 1'b1;
						ok    = (byte_in == rfp_pkg::BYTE_TAG1);
					end
					rfp_pkg::POS_TAG2: begin
						check = 1'b1;
						ok    = (byte_in == rfp_pkg::BYTE_TAG2);
					end
					rfp_pkg::POS_VER_MAJ: begin
						check = 1'b1;
						ok    = (byte_in == cfg.ver_major);
					end
					rfp_pkg::POS_VER_MIN: begin
						check = 1'b1;
						ok    = (byte_in == cfg.ver_minor);
					end
					rfp_pkg::POS_END: begin
						check = 1'b1;
						ok    = (byte_in == rfp_pkg::BYTE_END);
					end
					rfp_pkg::POS_LEN_HI: begin
						check    = 1'b1;
						len_hi_n = byte_in;
					end
					rfp_pkg::POS_LEN_LO: begin
						// saturate for reporting; oversized lengths never reach the data phase
						len_n = full_len[15] ? rfp_pkg::LEN_SAT : full_len[rfp_pkg::LEN_W-1:0];
						if (full_len > {1'b0, cfg.max_len}) begin
							pos_n      = rfp_pkg::POS_START;
							res.status = rfp_pkg::ST_LEN_ERR;
							res.last   = 1'b1;
						end else begin
							pos_n = rfp_pkg::POS_CMD;
						end
					end
					rfp_pkg::POS_CMD: begin
						cmd_n  = byte_in;
						left_n = len_q;
						if (len_q == '0) begin
							pos_n      = rfp_pkg::POS_START;
							res.status = rfp_pkg::ST_COMPLETE;
							res.last   = 1'b1;
						end else begin
							pos_n = rfp_pkg::POS_DATA;
						end
					end
					default: begin
						// data phase
						left_n        = left_dec;
						res.data_byte = byte_in;
						if (left_dec == '0) begin
							pos_n      = rfp_pkg::POS_START;
							res.status = rfp_pkg::ST_COMPLETE;
							res.last   = 1'b1;
						end else begin
							pos_n      = rfp_pkg::POS_DATA;
							res.status = rfp_pkg::ST_DATA;
						end
					end
				endcase
				if (check) begin
					if (ok) begin
						pos_n = rfp_pkg::rfp_pos_t'(4'(pos_q) + 4'd1);
					end else begin
						pos_n      = rfp_pkg::POS_START;
						res.status = rfp_pkg::ST_FRAME_ERR;
						res.last   = 1'b1;
					end
				end
			end
			default: res_valid = 1'b0;
		endcase

		res.command       = cmd_n;
		res.length        = len_n;
		res.packet_number = num_n;
	end

endmodule

>>> src/response_frame_parser_core.sv
// Response frame parser: one input register, the parser step and the result register.
// Depends on rfp_pkg, rfp_regs and rfp_parser.
//
// Takes one request per clock while the result side does not stall: a new-number,
// received-byte or timeout operation on s_tuser with the byte on s_tdata. Each
// request is held in the input stage, stepped against the frame state by combinational
// logic, and its result lands in the output register; while m_tready holds high the
// sustained throughput is one request per cycle. The input stage also buffers one
// request while a result waits on m_tready. Operation 3 is dropped without a result.
// Configuration registers (major version at 0x0, minor version at 0x4, maximum length
// at 0x8) should be written only while no request is in flight.
module response_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_value[7:0]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // data_byte[7:0], command[15:8], length[30:16],
	                               // packet_number[38:31], zero[39]
	output logic [2:0]  m_tuser,   // status[2:0]
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	rfp_pkg::rfp_cfg_t cfg;
	rfp_pkg::rfp_res_t res;
	rfp_pkg::rfp_res_t res_q;
	rfp_pkg::rfp_op_t  op_s1;
	logic [7:0]        byte_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic              advance;
	logic              fire;
	logic              res_valid;

	rfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the input stage whenever the result register is free or draining
	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= rfp_pkg::rfp_op_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
	end

	rfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.op        (op_s1),
		.byte_in   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.packet_number, res_q.length, res_q.command,
	                   res_q.data_byte};
	assign m_tuser  = res_q.status;
	assign m_tlast  = res_q.last;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for response_frame_parser_core: random and directed frames
// go in through the request stream, results are checked against a frame predictor.
// Depends on rfp_pkg and response_frame_parser_core.
module tb;

	localparam int CYCLE_LIMIT = 250000;

	// Frame predictor plus the queue of results it owes the block.
	class frame_result_book;
		rfp_pkg::rfp_res_t         due[$];
		int                        errors;
		int                        n_checked;
		int                        n_frames;
		logic [7:0]                ver_major = 8'd1;
		logic [7:0]                ver_minor = 8'd0;
		logic [rfp_pkg::LEN_W-1:0] max_len = 15'd1024;
		rfp_pkg::rfp_pos_t         pos = rfp_pkg::POS_START;
		logic [7:0]                len_hi = '0;
		logic [15:0]               frame_len = '0;
		logic [15:0]               left = '0;
		logic [7:0]                cmd = '0;
		logic [7:0]                cur_num = '0;

		function void write_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				rfp_pkg::REG_VER_MAJ: ver_major = v[7:0];
				rfp_pkg::REG_VER_MIN: ver_minor = v[7:0];
				rfp_pkg::REG_MAX_LEN: max_len = v[rfp_pkg::LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function rfp_pkg::rfp_res_t outcome(rfp_pkg::rfp_status_t st, logic [7:0] d,
			logic lst);
			rfp_pkg::rfp_res_t r;
			r.status = st;
			r.data_byte = d;
			r.command = cmd;
			r.length = (frame_len > 16'h7FFF) ? rfp_pkg::LEN_SAT
				: frame_len[rfp_pkg::LEN_W-1:0];
			r.packet_number = cur_num;
			r.last = lst;
			if (st == rfp_pkg::ST_COMPLETE)
				n_frames++;
			return r;
		endfunction

		function void take_request(rfp_pkg::rfp_op_t op, logic [7:0] b);
			logic ok;
			ok = 1'b1;
			case (op)
				rfp_pkg::OP_NEW_NUMBER: begin
					cur_num = cur_num + 8'd1;
					if (cur_num == 8'h00 || cur_num == rfp_pkg::NUM_WILD)
						cur_num = cur_num + 8'd1;
					pos = rfp_pkg::POS_START;
					due.push_back(outcome(rfp_pkg::ST_NUMBER, 8'h00, 1'b0));
					return;
				end
				rfp_pkg::OP_TIMEOUT: begin
					pos = rfp_pkg::POS_START;
					due.push_back(outcome(rfp_pkg::ST_TIMEOUT, 8'h00, 1'b1));
					return;
				end
				rfp_pkg::OP_UNUSED: return;
				default: ;
			endcase
			case (pos)
				rfp_pkg::POS_START: begin
					ok = (b == rfp_pkg::BYTE_START);
					if (ok) begin
						frame_len = '0;
						cmd = '0;
						left = '0;
					end
				end
				rfp_pkg::POS_SYNC1:   ok = (b == rfp_pkg::BYTE_SYNC1);
				rfp_pkg::POS_SYNC2:   ok = (b == rfp_pkg::BYTE_SYNC2);
				rfp_pkg::POS_NUMBER:  ok = (b == cur_num || b == rfp_pkg::NUM_WILD);
				rfp_pkg::POS_TAG0:    ok = (b == rfp_pkg::BYTE_TAG0);
				rfp_pkg::POS_TAG1:    ok = (b == rfp_pkg::BYTE_TAG1);
				rfp_pkg::POS_TAG2:    ok = (b == rfp_pkg::BYTE_TAG2);
				rfp_pkg::POS_VER_MAJ: ok = (b == ver_major);
				rfp_pkg::POS_VER_MIN: ok = (b == ver_minor);
				rfp_pkg::POS_END:     ok = (b == rfp_pkg::BYTE_END);
				rfp_pkg::POS_LEN_HI:  len_hi = b;
				rfp_pkg::POS_LEN_LO: begin
					frame_len = {len_hi, b};
					if (frame_len > {1'b0, max_len}) begin
						pos = rfp_pkg::POS_START;
						due.push_back(outcome(rfp_pkg::ST_LEN_ERR, 8'h00, 1'b1));
						return;
					end
				end
				rfp_pkg::POS_CMD: begin
					cmd = b;
					left = frame_len;
					if (left == 16'd0) begin
						pos = rfp_pkg::POS_START;
						due.push_back(outcome(rfp_pkg::ST_COMPLETE, 8'h00, 1'b1));
					end else begin
						pos = rfp_pkg::POS_DATA;
						due.push_back(outcome(rfp_pkg::ST_HEADER, 8'h00, 1'b0));
					end
					return;
				end
				default: begin
					if (left != 16'd0)
						left = left - 16'd1;
					if (left == 16'd0) begin
						pos = rfp_pkg::POS_START;
						due.push_back(outcome(rfp_pkg::ST_COMPLETE, b, 1'b1));
					end else begin
						pos = rfp_pkg::POS_DATA;
						due.push_back(outcome(rfp_pkg::ST_DATA, b, 1'b0));
					end
					return;
				end
			endcase
			if (!ok) begin
				pos = rfp_pkg::POS_START;
				due.push_back(outcome(rfp_pkg::ST_FRAME_ERR, 8'h00, 1'b1));
			end else begin
				pos = rfp_pkg::rfp_pos_t'(pos + 1);
				due.push_back(outcome(rfp_pkg::ST_HEADER, 8'h00, 1'b0));
			end
		endfunction

		function void check_result(rfp_pkg::rfp_res_t got, logic pad);
			rfp_pkg::rfp_res_t want;
			if (due.size() == 0) begin
				$error("result with nothing pending: status %0d", got.status);
				errors++;
				return;
			end
			want = due.pop_front();
			n_checked++;
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.data_byte !== want.data_byte) begin
				$error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
				errors++;
			end
			if (got.command !== want.command) begin
				$error("command: expected %0h, got %0h", want.command, got.command);
				errors++;
			end
			if (got.length !== want.length) begin
				$error("length: expected %0d, got %0d", want.length, got.length);
				errors++;
			end
			if (got.packet_number !== want.packet_number) begin
				$error("packet_number: expected %0h, got %0h",
					want.packet_number, got.packet_number);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
			if (pad !== 1'b0) begin
				$error("tdata pad bit: expected 0, got %0b", pad);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	frame_result_book book = new();
	int n_sent = 0;
	int tx_idle_pct = 30;
	int rx_idle_pct = 30;
	int rx_hold = 0;
	int cycle_count = 0;
	int reg_errors = 0;

	response_frame_parser_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		rfp_pkg::rfp_res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = rfp_pkg::rfp_status_t'(m_tuser);
			got.data_byte = m_tdata[7:0];
			got.command = m_tdata[15:8];
			got.length = m_tdata[30:16];
			got.packet_number = m_tdata[38:31];
			got.last = m_tlast;
			book.check_result(got, m_tdata[39]);
		end
	end

	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	// Result side: random stalls, plus a long hold when the stimulus asks for one.
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else begin
				stall = pick_gap(rx_idle_pct);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_request(rfp_pkg::rfp_op_t op, logic [7:0] b);
		int gap;
		gap = pick_gap(tx_idle_pct);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		book.take_request(op, b);
		if (op != rfp_pkg::OP_UNUSED)
			n_sent++;
	endtask

	// Drop valid, wait for every pending result, then let the pipeline empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (book.due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write a register, then read it back.
	task automatic reg_access(logic [1:0] idx, logic [31:0] v);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		book.write_reg(idx, v);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			rfp_pkg::REG_VER_MAJ: want = {24'd0, book.ver_major};
			rfp_pkg::REG_VER_MIN: want = {24'd0, book.ver_minor};
			default:              want = {17'd0, book.max_len};
		endcase
		if (prdata !== want) begin
			$error("prdata: expected %0h, got %0h", want, prdata);
			reg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [7:0] maj, logic [7:0] mnr, logic [14:0] maxl);
		reg_access(rfp_pkg::REG_VER_MAJ, {24'd0, maj});
		reg_access(rfp_pkg::REG_VER_MIN, {24'd0, mnr});
		reg_access(rfp_pkg::REG_MAX_LEN, {17'd0, maxl});
	endtask

	// Header with the expected number (or the wildcard), then ndata data bytes.
	// bad_at flips one header byte when it is 0..12.
	task automatic send_frame(logic [15:0] len, int ndata, int bad_at);
		logic [7:0] hdr [13];
		logic [7:0] num;
		num = ($urandom_range(3) == 0) ? rfp_pkg::NUM_WILD : book.cur_num;
		hdr = '{rfp_pkg::BYTE_START, rfp_pkg::BYTE_SYNC1, rfp_pkg::BYTE_SYNC2, num,
			rfp_pkg::BYTE_TAG0, rfp_pkg::BYTE_TAG1, rfp_pkg::BYTE_TAG2,
			book.ver_major, book.ver_minor, rfp_pkg::BYTE_END, len[15:8], len[7:0],
			8'($urandom)};
		if (bad_at >= 0 && bad_at < 13)
			hdr[bad_at] = hdr[bad_at] ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < 13; i++)
			send_request(rfp_pkg::OP_BYTE, hdr[i]);
		for (int i = 0; i < ndata; i++)
			send_request(rfp_pkg::OP_BYTE, 8'($urandom));
	endtask

	function automatic logic [15:0] pick_len();
		int top;
		top = (book.max_len < 6) ? int'(book.max_len) : 6;
		if (book.max_len <= 40 && $urandom_range(7) == 0)
			return 16'(book.max_len);
		return 16'($urandom_range(0, top));
	endfunction

	function automatic logic [15:0] oversize_len();
		int m;
		m = int'(book.max_len);
		case ($urandom_range(2))
			0:       return 16'(m + 1);
			1:       return 16'($urandom_range(m + 1, 16'hFFFF));
			default: return 16'h8000 | 16'($urandom);
		endcase
	endfunction

	task automatic random_step();
		int pick;
		int ndata;
		logic [15:0] len;
		pick = $urandom_range(99);
		if (pick < 55) begin
			len = pick_len();
			send_frame(len, int'(len), -1);
		end else if (pick < 65) begin
			len = pick_len();
			send_frame(len, int'(len), $urandom_range(0, 9));
		end else if (pick < 73) begin
			send_frame(oversize_len(), $urandom_range(0, 2), -1);
		end else if (pick < 80) begin
			// cut the frame short, then abort it
			len = (book.max_len == 0) ? 16'd0 : 16'($urandom_range(1, book.max_len));
			ndata = (len == 0) ? 0 : $urandom_range(0, (len > 5) ? 4 : len - 1);
			send_frame(len, ndata, -1);
			send_request($urandom_range(1) ? rfp_pkg::OP_TIMEOUT : rfp_pkg::OP_NEW_NUMBER,
				8'($urandom));
		end else if (pick < 88) begin
			send_request(rfp_pkg::OP_NEW_NUMBER, 8'($urandom));
		end else if (pick < 92) begin
			send_request(rfp_pkg::OP_TIMEOUT, 8'($urandom));
		end else if (pick < 96) begin
			send_request(rfp_pkg::OP_UNUSED, 8'($urandom));
		end else begin
			send_request(rfp_pkg::OP_BYTE, 8'($urandom));
		end
	endtask

	task automatic run_random(int n);
		int target;
		target = n_sent + n;
		while (n_sent < target)
			random_step();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, every operation, idle errors, empty and oversized frames
		send_request(rfp_pkg::OP_TIMEOUT, 8'h00);
		send_request(rfp_pkg::OP_BYTE, 8'h00);
		send_request(rfp_pkg::OP_UNUSED, 8'hFF);
		send_request(rfp_pkg::OP_BYTE, 8'hFF);
		send_request(rfp_pkg::OP_NEW_NUMBER, 8'h00);
		send_frame(16'd0, 0, -1);
		send_frame(16'hFFFF, 0, -1);
		send_frame(16'd2, 2, -1);

		// walk the packet number through its wrap, past the skipped values
		for (int i = 0; i < 256; i++)
			send_request(rfp_pkg::OP_NEW_NUMBER, 8'($urandom));
		settle();

		// widest settings, no idling on either side
		set_config(8'hFF, 8'hFF, 15'h7FFF);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_frame(16'h7FFF, 3, -1);
		send_request(rfp_pkg::OP_TIMEOUT, 8'h00);
		send_frame(16'h8000, 0, -1);
		run_random(30);
		settle();

		// narrowest settings: only empty frames fit
		set_config(8'h00, 8'h00, 15'd0);
		tx_idle_pct = 40;
		rx_idle_pct = 40;
		run_random(20);
		settle();

		// random versions, small length cap, then a long receiver hold
		set_config(8'($urandom), 8'($urandom), 15'($urandom_range(1, 12)));
		tx_idle_pct = 25;
		rx_idle_pct = 25;
		run_random(25);
		tx_idle_pct = 0;
		rx_hold = 80;
		run_random(15);
		settle();

		set_config(8'd1, 8'd0, 15'd1024);
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		run_random(25);
		settle();
		repeat (6) @(posedge clk);

		$display("requests sent %0d, results checked %0d, frames completed %0d",
			n_sent, book.n_checked, book.n_frames);
		$display("five register settings, number wrap, framing, length and timeout errors");
		if (book.errors == 0 && reg_errors == 0 && book.due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

>>> files.f
src/rfp_pkg.sv
src/rfp_regs.sv
src/rfp_parser.sv
src/response_frame_parser_core.sv
tb/tb.sv
